/* sv/upd_pkg.sv */
// upd_pkg: shared widths, reset constant and controller/datapath interface structs
// for the ulam permutation distance block; no dependencies
`default_nettype none

package upd_pkg;

    localparam int ELEM_W  = 6;
    localparam int CFG_W   = 7;
    localparam int DIST_W  = 6;
    localparam int CFG_RST = 64;

    typedef struct packed {
        logic load;
        logic emit_err;
        logic start_lis;
        logic init_search;
        logic step;
        logic write_tail;
        logic emit_lis;
    } t_cmd;

    typedef struct packed {
        logic last_item;
        logic err_any;
        logic search_open;
        logic last_elem;
    } t_sts;

endpackage

`default_nettype wire

/* sv/upd_ram.sv */
// upd_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module upd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/upd_dp.sv */
// upd_dp: datapath with length register, load counters, inverse/store/tails memories,
// binary search registers and result register; depends on upd_pkg and upd_ram
`default_nettype none

module upd_dp import upd_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic [ELEM_W-1:0] i_first_elem,
    input  wire logic [ELEM_W-1:0] i_second_elem,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic                   o_strobe,
    output logic [DIST_W-1:0]      o_distance,
    output logic                   o_range_error
);

    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);
    localparam int LW      = (CW > CFG_W) ? CW : CFG_W;
    localparam int LEN_RST = (MAX_LEN < CFG_RST) ? MAX_LEN : CFG_RST;

    logic [CW-1:0]     r_len, n_len;
    logic [AW-1:0]     r_pos;
    logic              r_err_seen;
    logic [AW-1:0]     r_i;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [AW-1:0]     r_x;
    logic              r_strobe;
    logic [DIST_W-1:0] r_dist;
    logic              r_rerr;

    logic [LW-1:0]     w_cfg_ext;
    logic              w_a_bad;
    logic              w_b_bad;
    logic [CW-1:0]     w_mid;
    logic [ELEM_W-1:0] w_sec_rdata;
    logic [AW-1:0]     w_inv_rdata;
    logic [AW-1:0]     w_tail_rdata;

    // clamp the written length into 1..MAX_LEN
    always_comb begin
        w_cfg_ext = LW'(i_cfg_wdata);
        if (i_cfg_wdata == '0) begin
            n_len = CW'(1);
        end else if (w_cfg_ext > LW'(MAX_LEN)) begin
            n_len = CW'(MAX_LEN);
        end else begin
            n_len = CW'(w_cfg_ext);
        end
    end

    assign w_a_bad = LW'(i_first_elem) >= LW'(r_len);
    assign w_b_bad = LW'(i_second_elem) >= LW'(r_len);
    assign w_mid   = r_lo + ((r_hi - r_lo) >> 1);

    assign o_sts.last_item   = (CW'(r_pos) + CW'(1)) >= r_len;
    assign o_sts.err_any     = r_err_seen | w_a_bad | w_b_bad;
    assign o_sts.search_open = r_lo < r_hi;
    assign o_sts.last_elem   = (CW'(r_i) + CW'(1)) >= r_len;

    upd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_inv (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load & ~w_a_bad),
        .i_waddr (AW'(i_first_elem)),
        .i_wdata (r_pos),
        .i_raddr (AW'(w_sec_rdata)),
        .o_rdata (w_inv_rdata)
    );

    upd_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_sec (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_pos),
        .i_wdata (i_second_elem),
        .i_raddr (r_i),
        .o_rdata (w_sec_rdata)
    );

    upd_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_tails (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_tail),
        .i_waddr (r_lo[AW-1:0]),
        .i_wdata (r_x),
        .i_raddr (w_mid[AW-1:0]),
        .o_rdata (w_tail_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= CW'(LEN_RST);
            r_pos      <= '0;
            r_err_seen <= 1'b0;
            r_i        <= '0;
            r_count    <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_err | i_cmd.emit_lis;

            if (i_cfg_we) begin
                r_len      <= n_len;
                r_pos      <= '0;
                r_err_seen <= 1'b0;
            end else if (i_cmd.load) begin
                if (o_sts.last_item) begin
                    r_pos      <= '0;
                    r_err_seen <= 1'b0;
                end else begin
                    r_pos      <= r_pos + AW'(1);
                    r_err_seen <= o_sts.err_any;
                end
            end

            if (i_cmd.start_lis) begin
                r_i     <= '0;
                r_count <= '0;
            end

            if (i_cmd.init_search) begin
                r_x  <= w_inv_rdata;
                r_lo <= '0;
                r_hi <= r_count;
            end

            // first tail that is not below x
            if (i_cmd.step) begin
                if (w_tail_rdata < r_x) begin
                    r_lo <= w_mid + CW'(1);
                end else begin
                    r_hi <= w_mid;
                end
            end

            if (i_cmd.write_tail) begin
                if (r_lo == r_count) begin
                    r_count <= r_count + CW'(1);
                end
                r_i <= r_i + AW'(1);
            end

            if (i_cmd.emit_err) begin
                r_dist <= '0;
                r_rerr <= 1'b1;
            end else if (i_cmd.emit_lis) begin
                r_dist <= DIST_W'(r_len - r_count);
                r_rerr <= 1'b0;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_distance    = r_dist;
    assign o_range_error = r_rerr;

endmodule

`default_nettype wire

/* sv/upd_ctrl.sv */
// upd_ctrl: controller state machine sequencing load, map, binary search and result
// depends on upd_pkg
`default_nettype none

module upd_ctrl import upd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_MAP   = 7'b0000100,
        S_INIT  = 7'b0001000,
        S_PROBE = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.last_item) begin
                        if (i_sts.err_any) begin
                            o_cmd.emit_err = 1'b1;
                        end else begin
                            o_cmd.start_lis = 1'b1;
                            n_state         = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_state = S_MAP;
            end
            S_MAP: begin
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_search = 1'b1;
                n_state           = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.search_open) begin
                    n_state = S_CMP;
                end else begin
                    o_cmd.write_tail = 1'b1;
                    n_state          = i_sts.last_elem ? S_DONE : S_FETCH;
                end
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = S_PROBE;
            end
            S_DONE: begin
                o_cmd.emit_lis = 1'b1;
                n_state        = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_LOAD);

endmodule

`default_nettype wire

/* sv/ulam_permutation_distance.sv */
// ulam_permutation_distance: top level, Ulam distance of two permutations by patience sort
// depends on upd_pkg, upd_ctrl, upd_dp (which holds three upd_ram instances)
//
//   channel   handshake                 payload
//   input     start, busy               i_first_elem, i_second_elem
//   result    o_strobe (one cycle)      o_distance, o_range_error
//   config    i_cfg_we                  i_cfg_wdata
//
// a pair is loaded whenever start is high while idle; busy stays low while pairs are loaded
// after the last pair the result follows in the next cycle on a range error; otherwise each element
// is fetched, mapped and placed by binary search over the tails, each probe waiting on the tails read
// synchronous active-low reset, no clearing pass; results cannot be stalled
`default_nettype none

module ulam_permutation_distance import upd_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ELEM_W-1:0] i_first_elem,
    input  wire logic [ELEM_W-1:0] i_second_elem,
    output logic                   o_strobe,
    output logic [DIST_W-1:0]      o_distance,
    output logic                   o_range_error,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    upd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    upd_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_first_elem  (i_first_elem),
        .i_second_elem (i_second_elem),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_strobe      (o_strobe),
        .o_distance    (o_distance),
        .o_range_error (o_range_error)
    );

endmodule

`default_nettype wire
